>>> design/btsw_pkg.sv
// Shared types and constants for the button-tuned square-wave generator.
package btsw_pkg;

  localparam int FREQ_W     = 14;
  localparam int NUM_W      = 24;
  localparam int DIVISOR_W  = FREQ_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0]  CLOCK_NUM_RESET = NUM_W'(15999);
  localparam logic [FREQ_W-1:0] FREQ_MAX_RESET  = FREQ_W'(16000);
  localparam logic [FREQ_W-1:0] FREQ_MIN_RESET  = FREQ_W'(1);
  localparam logic [FREQ_W-1:0] FREQ_RESET      = FREQ_W'(30);
  localparam int                COUNT_RESET     = 533;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_NUMERATOR = 2'd0,
    REG_FREQ_MAX        = 2'd1,
    REG_FREQ_MIN        = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic mode;
    logic up_press;
    logic down_press;
  } in_item_t;

  typedef struct packed {
    logic              pin_level;
    logic [FREQ_W-1:0] freq_now;
    logic              wrapped;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic load_reload;
  } btsw_cmd_t;

  typedef struct packed {
    logic wrap_req;
    logic div_done;
  } btsw_status_t;

endpackage

>>> design/btsw_div.sv
// Restoring divider that produces one quotient bit per cycle.
module btsw_div import btsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [NUM_W-1:0]     quotient
);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] rem;
  logic [NUM_W-1:0]     qr;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  always_comb begin
    trial = {rem, qr[NUM_W-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr  <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? DIVISOR_W'(trial - {1'b0, dsr}) : DIVISOR_W'(trial);
      qr  <= {qr[NUM_W-2:0], ge};
    end
  end

  assign quotient = qr;

endmodule

>>> design/btsw_dp.sv
// Datapath: configuration, frequency step, tick counter, phase and output register.
module btsw_dp import btsw_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  btsw_cmd_t             cmd,
  output btsw_status_t          status,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [NUM_W-1:0]       clock_numerator;
  logic [FREQ_W-1:0]      freq_max;
  logic [FREQ_W-1:0]      freq_min;
  logic [FREQ_W-1:0]      freq_value;
  logic [FREQ_W-1:0]      freq_value_next;
  logic [COUNT_WIDTH-1:0] down_count;
  logic [COUNT_WIDTH-1:0] reload_value;
  logic [COUNT_WIDTH-1:0] reload_next;
  logic                   phase_flag;
  logic                   pin_state;
  logic                   pin_state_next;
  logic                   freq_zero;
  logic                   tick_wrap;
  logic                   div_done;
  logic [NUM_W-1:0]       quotient;
  logic [NUM_W+COUNT_WIDTH-1:0] quot_ext;

  btsw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (clock_numerator),
    .divisor  ({freq_value, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  assign tick_wrap       = down_count == '0;
  assign status.wrap_req = !in_data.mode && tick_wrap;
  assign status.div_done = div_done;

  always_comb begin
    freq_value_next = freq_value;
    if (in_data.mode) begin
      if (in_data.up_press && !in_data.down_press && freq_value < freq_max) begin
        freq_value_next = freq_value + FREQ_W'(1);
      end else if (in_data.down_press && !in_data.up_press && freq_value > freq_min) begin
        freq_value_next = freq_value - FREQ_W'(1);
      end
    end
    pin_state_next = (!in_data.mode && tick_wrap) ? phase_flag : pin_state;
  end

  always_comb begin
    quot_ext = {{COUNT_WIDTH{1'b0}}, quotient};
    if (freq_zero || quot_ext[NUM_W+COUNT_WIDTH-1:COUNT_WIDTH] != '0) begin
      reload_next = CNT_MAX;
    end else if (quot_ext[COUNT_WIDTH-1:0] == '0) begin
      reload_next = COUNT_WIDTH'(1);
    end else begin
      reload_next = quot_ext[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_numerator <= CLOCK_NUM_RESET;
      freq_max        <= FREQ_MAX_RESET;
      freq_min        <= FREQ_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_NUMERATOR: clock_numerator <= cfg_data[NUM_W-1:0];
        REG_FREQ_MAX:        freq_max        <= cfg_data[FREQ_W-1:0];
        REG_FREQ_MIN:        freq_min        <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_value   <= FREQ_RESET;
      down_count   <= COUNT_WIDTH'(COUNT_RESET);
      reload_value <= COUNT_WIDTH'(COUNT_RESET);
      phase_flag   <= 1'b1;
      pin_state    <= 1'b0;
      freq_zero    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        freq_value <= freq_value_next;
        pin_state  <= pin_state_next;
        if (!in_data.mode) begin
          if (tick_wrap) begin
            down_count <= reload_value;
            phase_flag <= !phase_flag;
          end else begin
            down_count <= down_count - COUNT_WIDTH'(1);
          end
        end
      end
      if (cmd.start_div) begin
        freq_zero <= freq_value == '0;
      end
      if (cmd.load_reload) begin
        reload_value <= reload_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data.pin_level <= pin_state_next;
      out_data.freq_now  <= freq_value_next;
      out_data.wrapped   <= !in_data.mode && tick_wrap;
    end
  end

endmodule

>>> design/btsw_ctrl.sv
// Controller: input and output handshakes and sequencing of the reload division.
module btsw_ctrl import btsw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  btsw_status_t status,
  output btsw_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.start_div   = 1'b0;
    cmd.load_reload = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = !out_valid || out_ready;
        cmd.accept    = in_valid && in_ready;
        cmd.start_div = cmd.accept && status.wrap_req;
        if (cmd.start_div) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.load_reload = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.accept) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> design/button_tuned_square_wave.sv
// Top level of the button-tuned square-wave generator.
//
//   channel | signals                        | payload
//   --------+--------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_data    | mode, up_press, down_press
//   output  | out_valid, out_ready, out_data | pin_level, freq_now, wrapped
//   config  | cfg_we, cfg_index, cfg_data    | clock_numerator, freq_max, freq_min
//
// Buttons and ticks that do not wrap need no division; the result is registered.
// A wrapping tick starts the reload division in the bit-serial divider; in_ready
// stays low in ST_DIV until the divider is done, when the reload value is written
// and the controller returns to ST_IDLE to accept the next item.
// A result that is not taken holds off the next item only while it is still waiting.
// Reset is synchronous; all but out_data and the divider operands get defaults.
module button_tuned_square_wave import btsw_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  btsw_cmd_t    cmd;
  btsw_status_t status;

  btsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  btsw_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> design/btsw_chk.sv
// Port-level checker for the button-tuned square-wave generator and its bind.
module btsw_chk import btsw_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_ready_needs_slot: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output slot is full");

  a_button_no_wrap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode |=> !out_data.wrapped)
    else $error("button item reported a wrap");

endmodule

bind button_tuned_square_wave btsw_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> dv/button_tuned_square_wave_test.sv
// Self-checking testbench for the button-tuned square-wave generator.
module button_tuned_square_wave_test;
  import btsw_pkg::*;

  localparam int COUNT_W = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS = 30;
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_BUTTON = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [NUM_W-1:0] cfg_numerator = CLOCK_NUM_RESET;
  logic [FREQ_W-1:0] cfg_freq_max = FREQ_MAX_RESET;
  logic [FREQ_W-1:0] cfg_freq_min = FREQ_MIN_RESET;
  logic [FREQ_W-1:0] step_freq = FREQ_RESET;
  logic [COUNT_W-1:0] tick_count = COUNT_W'(COUNT_RESET);
  logic [COUNT_W-1:0] held_reload = COUNT_W'(COUNT_RESET);
  logic next_level = 1'b1;
  logic pin_now = 1'b0;

  in_item_t button_tick_q[$];
  out_item_t expected_wave_q[$];
  logic in_fire = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  int idle_pct = 25;
  int stall_cycles = 0;
  int error_count = 0;

  button_tuned_square_wave #(.COUNT_WIDTH(COUNT_W)) uut (.*);

  always #6 clk = ~clk;

  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t res;
    logic [NUM_W-1:0] quo;
    res.wrapped = 1'b0;
    if (ev.mode == MODE_BUTTON) begin
      if (ev.up_press && !ev.down_press) begin
        if (step_freq < cfg_freq_max) step_freq = step_freq + 1'b1;
      end else if (ev.down_press && !ev.up_press) begin
        if (step_freq > cfg_freq_min) step_freq = step_freq - 1'b1;
      end
    end else if (tick_count == '0) begin
      res.wrapped = 1'b1;
      tick_count = held_reload;
      pin_now = next_level;
      next_level = ~next_level;
      // A zero frequency skips the division; a zero quotient is raised to one.
      if (step_freq == '0) begin
        held_reload = '1;
      end else begin
        quo = cfg_numerator / {step_freq, 1'b0};
        held_reload = (quo == '0) ? COUNT_W'(1) : COUNT_W'(quo);
      end
    end else begin
      tick_count = tick_count - 1'b1;
    end
    res.pin_level = pin_now;
    res.freq_now = step_freq;
    return res;
  endfunction

  function automatic void queue_event(logic mode, logic up, logic down);
    in_item_t ev;
    ev.mode = mode;
    ev.up_press = up;
    ev.down_press = down;
    button_tick_q.push_back(ev);
  endfunction

  function automatic void queue_ticks(int count);
    for (int k = 0; k < count; k++) begin
      queue_event(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endfunction

  function automatic void queue_random(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 70) begin
        queue_event(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        queue_event(MODE_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  task automatic wait_drained();
    while (button_tick_q.size() != 0 || in_valid || expected_wave_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CLOCK_NUMERATOR: cfg_numerator = val[NUM_W-1:0];
      REG_FREQ_MAX: cfg_freq_max = val[FREQ_W-1:0];
      REG_FREQ_MIN: cfg_freq_min = val[FREQ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else if (!in_valid || in_fire) begin
      if (send_gap == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(1, 5);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (button_tick_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= button_tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (take_gap == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        take_gap = $urandom_range(1, 5);
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        expected_wave_q.push_back(apply_event(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_wave_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected item: pin %0b freq %0d wrapped %0b",
                     out_data.pin_level, out_data.freq_now, out_data.wrapped);
          end
        end else begin
          want = expected_wave_q.pop_front();
          if (out_data.pin_level !== want.pin_level || out_data.freq_now !== want.freq_now
              || out_data.wrapped !== want.wrapped) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected pin %0b freq %0d wrapped %0b, got pin %0b freq %0d wrapped %0b",
                       want.pin_level, want.freq_now, want.wrapped,
                       out_data.pin_level, out_data.freq_now, out_data.wrapped);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("button_tuned_square_wave_test: done, errors");
      $finish;
    end
  end

  initial begin
    logic [NUM_W-1:0] numer;
    logic [FREQ_W-1:0] fmax;
    logic [FREQ_W-1:0] fmin;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_event(MODE_BUTTON, 1'b1, 1'b0);
    queue_event(MODE_BUTTON, 1'b0, 1'b1);
    queue_event(MODE_BUTTON, 1'b1, 1'b1);
    queue_event(MODE_BUTTON, 1'b0, 1'b0);
    queue_event(MODE_TICK, 1'b0, 1'b0);
    queue_event(MODE_TICK, 1'b1, 1'b0);
    queue_event(MODE_TICK, 1'b0, 1'b1);
    queue_event(MODE_TICK, 1'b1, 1'b1);
    queue_event(MODE_BUTTON, 1'b1, 1'b0);
    queue_event(MODE_BUTTON, 1'b1, 1'b0);
    queue_event(MODE_BUTTON, 1'b0, 1'b1);
    queue_event(MODE_BUTTON, 1'b0, 1'b1);
    queue_event(MODE_BUTTON, 1'b0, 1'b1);

    // Run the counter out of its reset value; a numerator of one gives a zero quotient.
    wait_drained();
    write_reg(REG_CLOCK_NUMERATOR, CFG_DATA_W'(1));
    queue_ticks(int'(tick_count) + int'(held_reload) + 2);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      numer = NUM_W'($urandom_range(1, 400));
      fmin = FREQ_W'($urandom_range(1, 30));
      fmax = fmin + FREQ_W'($urandom_range(0, 40));
      idle_pct = (p % 2 == 0 && p != 6) ? 25 : 0;
      case (p)
        0: begin
          numer = NUM_W'($urandom_range(1, 300));
          fmax = '1;
          fmin = FREQ_W'(1);
        end
        1: numer = NUM_W'(1);
        2: begin
          fmax = FREQ_W'(1);
          fmin = FREQ_W'(1);
        end
        3: begin
          fmax = '1;
          fmin = '1;
        end
        4: write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        default: ;
      endcase
      write_reg(REG_CLOCK_NUMERATOR, numer);
      write_reg(REG_FREQ_MAX, {(CFG_DATA_W-FREQ_W)'($urandom), fmax});
      write_reg(REG_FREQ_MIN, {(CFG_DATA_W-FREQ_W)'($urandom), fmin});
      queue_random(PHASE_ITEMS);
    end

    // Wrap once at zero frequency, then once more with the largest numerator.
    // The counter then holds its largest value, so no further wrap can occur.
    wait_drained();
    idle_pct = 0;
    write_reg(REG_FREQ_MIN, '0);
    write_reg(REG_CLOCK_NUMERATOR, '1);
    for (int k = 0; k < int'(step_freq); k++) begin
      queue_event(MODE_BUTTON, 1'b0, 1'b1);
    end
    queue_ticks(int'(tick_count) + 1);
    wait_drained();
    queue_event(MODE_BUTTON, 1'b1, 1'b0);
    queue_ticks(int'(tick_count) + 1);
    queue_random(40);
    wait_drained();

    if (error_count == 0) begin
      $display("button_tuned_square_wave_test: done, clean");
    end else begin
      $display("button_tuned_square_wave_test: done, errors");
    end
    $finish;
  end

endmodule
